>>> sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Shared types, sizes and codes for the deadline-ordered timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int BURST_W     = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_WINDOW = 2'd2;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_STOPPED = 2'd2;

    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [30:0] delay;
        logic [7:0]  timer_type;
        logic [31:0] owner_id;
        logic [15:0] info;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] event_owner;
        logic [8:0]  event_code;
        logic [7:0]  event_info;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  kind;
        logic [31:0] owner;
        logic [7:0]  extra;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_CMP,
        ST_SET_WR,
        ST_REJECT,
        ST_LIMIT,
        ST_POP
    } state_t;

    typedef struct packed {
        logic capture;
        logic tick;
        logic limit_load;
        logic compare;
        logic insert;
        logic pop;
        logic reject;
    } cmd_t;

    typedef struct packed {
        logic in_mode;
        logic full;
        logic halted;
        logic front_due;
        logic front_last;
        logic out_free;
    } status_t;

endpackage

>>> sv/sorted_timeout_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue unit
// Deadline-ordered timer table with expiry bursts and a halting stop timer.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready). A set request stores a timer
// in deadline order, equal deadlines first-in first-out; it produces no result
// unless the table is full, in which case one rejected result is returned.
// A tick request advances time by one and pops every due timer up to and
// including the first stop timer, one result per cycle at most, with last
// marking the final result of that tick. Results leave on the m_ channel
// through an output register. One request is handled at a time. A set
// passes through a compare state and a write state before the next request
// is accepted; a rejected set loads its result in a reject state once the
// output register is free, and the next request is taken after that. A tick
// loads its due limit, then pops one result per cycle while the receiver takes them.
// The insertion compare across all slots is registered, which sets the set
// request length. When the receiver stalls, the controller waits with the
// result held and accepts nothing new. Reset empties the table, clears time,
// loads the register defaults and leaves the block running; after a stop timer
// expires, requests are still taken but ignored until reset.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [stq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  stq_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output stq_pkg::out_item_t             m_data
);
    import stq_pkg::*;

    cmd_t    cmd;
    status_t status;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop || cmd.reject) |-> status.out_free)
        else $error("Result register loaded while a result is pending.");

    a_reject_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reject |=> (m_valid && m_data.last && (m_data.kind == KIND_FULL)))
        else $error("Rejected set did not produce a final full result.");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.halted |=> status.halted)
        else $error("Halted state cleared without reset.");

    a_stop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind == KIND_STOPPED)) |-> m_data.last)
        else $error("Stopped result is not the final result.");
`endif

endmodule

>>> sv/stq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue controller
// Sequences capture, sorted insertion, rejection and expiry bursts.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  stq_pkg::status_t status,
    output stq_pkg::cmd_t    cmd
);
    import stq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !status.halted) begin
                    if (status.in_mode == MODE_TICK) begin
                        state_next = ST_LIMIT;
                    end else if (status.full) begin
                        state_next = ST_REJECT;
                    end else begin
                        state_next = ST_SET_CMP;
                    end
                end
            end
            ST_SET_CMP: state_next = ST_SET_WR;
            ST_SET_WR:  state_next = ST_IDLE;
            ST_REJECT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIMIT: state_next = ST_POP;
            ST_POP: begin
                if (!status.front_due) begin
                    state_next = ST_IDLE;
                end else if (status.out_free && status.front_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = accept && !status.halted;
                cmd.tick    = accept && !status.halted && (status.in_mode == MODE_TICK);
            end
            ST_SET_CMP: cmd.compare    = 1'b1;
            ST_SET_WR:  cmd.insert     = 1'b1;
            ST_REJECT:  cmd.reject     = status.out_free;
            ST_LIMIT:   cmd.limit_load = 1'b1;
            ST_POP:     cmd.pop        = status.front_due && status.out_free;
            default:    cmd            = '0;
        endcase
    end

endmodule

>>> sv/stq_dp.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue datapath
// Time counter, configuration, the sorted row of timer slots and the
// result register.
// ----------------------------------------------------------------------------
module stq_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [stq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_wdata,
    input  stq_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output stq_pkg::out_item_t               m_data,
    input  stq_pkg::cmd_t                    cmd,
    output stq_pkg::status_t                 status
);
    import stq_pkg::*;

    localparam int NEXT_IDX = (QUEUE_DEPTH > 1) ? 1 : 0;

    logic [7:0]         stop_type_reg;
    logic [7:0]         code_offset_reg;
    logic [7:0]         early_window_reg;
    logic [31:0]        now_reg;
    logic [31:0]        limit_reg;
    logic [COUNT_W-1:0] used_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               halted_reg;
    in_item_t           req_reg;
    logic [31:0]        new_deadline_reg;
    logic [QUEUE_DEPTH-1:0] le_reg;
    slot_t              slot_reg [QUEUE_DEPTH];
    slot_t              slot_next [QUEUE_DEPTH];
    slot_t              slot_prev [QUEUE_DEPTH];
    slot_t              slot_after [QUEUE_DEPTH];
    slot_t              new_slot;
    out_item_t          out_reg;
    out_item_t          out_next;
    logic               out_valid_reg;

    logic [QUEUE_DEPTH-1:0] le_cmb;
    logic [QUEUE_DEPTH:0]   pre;
    logic [31:0]            diff0;
    logic [31:0]            diff1;
    logic                   front_stop;
    logic                   out_free;

    assign new_slot = '{deadline: new_deadline_reg, kind: req_reg.timer_type,
                        owner: req_reg.owner_id, extra: req_reg.info[7:0]};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_nbr
            if (g == 0) begin : g_first
                assign slot_prev[g] = new_slot;
            end else begin : g_rest
                assign slot_prev[g] = slot_reg[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign slot_after[g] = slot_reg[g];
            end else begin : g_body
                assign slot_after[g] = slot_reg[g+1];
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le_cmb[i] = (COUNT_W'(i) < used_reg) &&
                        ((slot_reg[i].deadline - now_reg) <= {1'b0, req_reg.delay});
        end
    end

    always_comb begin
        pre[0] = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pre[i+1] = pre[i] && le_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_next[i] = slot_reg[i];
            if (cmd.insert) begin
                if (!pre[i]) begin
                    slot_next[i] = slot_prev[i];
                end else if (!le_reg[i]) begin
                    slot_next[i] = new_slot;
                end
            end else if (cmd.pop) begin
                slot_next[i] = slot_after[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign diff0      = limit_reg - slot_reg[0].deadline;
    assign diff1      = limit_reg - slot_reg[NEXT_IDX].deadline;
    assign front_stop = (slot_reg[0].kind == stop_type_reg);
    assign out_free   = !out_valid_reg || m_ready;

    assign status.in_mode    = s_data.mode;
    assign status.full       = (used_reg == COUNT_W'(QUEUE_DEPTH));
    assign status.halted     = halted_reg;
    assign status.front_due  = (used_reg != '0) && !diff0[31] &&
                               (burst_reg != BURST_W'(MAX_RESULTS));
    assign status.front_last = front_stop || (used_reg == COUNT_W'(1)) || diff1[31] ||
                               (burst_reg == BURST_W'(MAX_RESULTS - 1));
    assign status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_type_reg    <= 8'd255;
            code_offset_reg  <= 8'd0;
            early_window_reg <= 8'd1;
            now_reg          <= '0;
            used_reg         <= '0;
            halted_reg       <= 1'b0;
            burst_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STOP_TYPE:    stop_type_reg    <= cfg_wdata;
                    CFG_CODE_OFFSET:  code_offset_reg  <= cfg_wdata;
                    CFG_EARLY_WINDOW: early_window_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (cmd.tick) begin
                now_reg <= now_reg + 32'd1;
            end
            if (cmd.limit_load) begin
                burst_reg <= '0;
            end else if (cmd.pop) begin
                burst_reg <= burst_reg + BURST_W'(1);
            end
            if (cmd.insert) begin
                used_reg <= used_reg + COUNT_W'(1);
            end else if (cmd.pop) begin
                used_reg <= used_reg - COUNT_W'(1);
            end
            if (cmd.pop && front_stop) begin
                halted_reg <= 1'b1;
            end
            if (cmd.pop || cmd.reject) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.reject) begin
            out_next.kind        = KIND_FULL;
            out_next.event_owner = req_reg.owner_id;
            out_next.event_code  = {1'b0, req_reg.timer_type} + {1'b0, code_offset_reg};
            out_next.event_info  = req_reg.info[7:0];
            out_next.last        = 1'b1;
        end else if (cmd.pop) begin
            out_next.kind        = front_stop ? KIND_STOPPED : KIND_EXPIRED;
            out_next.event_owner = slot_reg[0].owner;
            out_next.event_code  = {1'b0, slot_reg[0].kind} + {1'b0, code_offset_reg};
            out_next.event_info  = slot_reg[0].extra;
            out_next.last        = status.front_last;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.limit_load) begin
            limit_reg <= now_reg + {24'd0, early_window_reg};
        end
        if (cmd.compare) begin
            le_reg           <= le_cmb;
            new_deadline_reg <= now_reg + {1'b0, req_reg.delay};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
